// ----- design/tgld_pkg.sv -----
// tgld_pkg: shared types, widths, reset values and register indexes
// for the touch gesture led dimmer; no dependencies
`default_nettype none

package tgld_pkg;

   localparam int TICK_COUNT_WIDTH_DEF = 16;
   localparam int DEBOUNCE_W = 10;
   localparam int MS_W       = 14;
   localparam int INTERVAL_W = 8;
   localparam int LEVEL_W    = 8;
   localparam int CSR_DATA_W = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
   localparam logic                  ACTIVE_RST   = 1'b1;
   localparam logic [MS_W-1:0]       MEDIUM_RST   = 14'd500;
   localparam logic [MS_W-1:0]       LONG_RST     = 14'd1000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd10;
   localparam logic                  GESTURE_RST  = 1'b1;
   localparam logic [LEVEL_W-1:0]    LEVEL_RST    = 8'd128;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEBOUNCE = 3'd0,
      REG_ACTIVE   = 3'd1,
      REG_MEDIUM   = 3'd2,
      REG_LONG     = 3'd3,
      REG_INTERVAL = 3'd4,
      REG_GESTURE  = 3'd5
   } tgld_reg_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic                  active_level;
      logic [MS_W-1:0]       medium_ms;
      logic [MS_W-1:0]       long_ms;
      logic [INTERVAL_W-1:0] ramp_interval_ms;
      logic                  gestures_enabled;
   } tgld_cfg_type;

   // classified tick handed from front to back
   typedef struct packed {
      logic short_press;
      logic pressed;
      logic hold_start;
      logic in_window;
   } tgld_event_type;

endpackage

`default_nettype wire

// ----- design/tgld_if.sv -----
// tgld_req_if / tgld_rsp_if: valid-ready channels of the dimmer
// depends on: nothing
`default_nettype none

interface tgld_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface tgld_rsp_if;
   logic       valid;
   logic       ready;
   logic       short_press;
   logic [7:0] pwm_duty;
   logic       led_on;
   logic [7:0] level_setting;
   logic       save_request;

   modport source (output valid, output short_press, output pwm_duty, output led_on,
                   output level_setting, output save_request, input ready);
   modport sink   (input valid, input short_press, input pwm_duty, input led_on,
                   input level_setting, input save_request, output ready);
endinterface

`default_nettype wire

// ----- design/touch_gesture_led_dimmer.sv -----
// touch_gesture_led_dimmer: top level, config registers, front, queue and back
// depends on: tgld_pkg, tgld_if, tgld_front, tgld_queue, tgld_back
//
//   channel   | direction | handshake        | carries
//   req_ch    | in        | valid / ready    | pin_level, one item per ms tick
//   rsp_ch    | out       | valid / ready    | short_press, pwm_duty, led_on,
//             |           |                  | level_setting, save_request
//   csr_*     | in        | csr_wr_en        | csr_index, csr_wdata (write only)
//
// the front takes one item per cycle while the queue has room; the back commits
// most items in the cycle it sees them, once rsp_ch is free; an item that starts
// a falling ramp passes issue, eight square root steps on the 8x8 multiplier, apply
// reset is synchronous and active high; it restores the config registers and control state
// a stalled rsp_ch holds the result register; the queue keeps the front going
`default_nettype none

module touch_gesture_led_dimmer #(
   parameter int TICK_COUNT_WIDTH = tgld_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tgld_req_if.sink                             req_ch,
   tgld_rsp_if.source                           rsp_ch,
   input  wire logic                            csr_wr_en,
   input  wire logic [tgld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tgld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tgld_pkg::*;

   tgld_cfg_type   cfg_ff;
   logic           push_valid, push_ready;
   tgld_event_type push_data;
   logic           pop_valid, pop_ready;
   tgld_event_type pop_data;

   // config registers, masked to their widths; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_RST;
         cfg_ff.active_level     <= ACTIVE_RST;
         cfg_ff.medium_ms        <= MEDIUM_RST;
         cfg_ff.long_ms          <= LONG_RST;
         cfg_ff.ramp_interval_ms <= INTERVAL_RST;
         cfg_ff.gestures_enabled <= GESTURE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEBOUNCE: cfg_ff.debounce_ms      <= csr_wdata[DEBOUNCE_W-1:0];
            REG_ACTIVE:   cfg_ff.active_level     <= csr_wdata[0];
            REG_MEDIUM:   cfg_ff.medium_ms        <= csr_wdata[MS_W-1:0];
            REG_LONG:     cfg_ff.long_ms          <= csr_wdata[MS_W-1:0];
            REG_INTERVAL: cfg_ff.ramp_interval_ms <= csr_wdata[INTERVAL_W-1:0];
            REG_GESTURE:  cfg_ff.gestures_enabled <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // debounce and press classification, including the long hold mark
   tgld_front #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples the front from square root stalls and rsp backpressure
   tgld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // led toggle, brightness ramp and result register
   tgld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/tgld_front.sv -----
// tgld_front: accepts ticks, debounces the pin and classifies each tick
// depends on: tgld_pkg, tgld_if
`default_nettype none

module tgld_front #(
   parameter int TICK_COUNT_WIDTH = tgld_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tgld_pkg::tgld_cfg_type  cfg,
   tgld_req_if.sink                     req_ch,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output tgld_pkg::tgld_event_type     push_data
);
   import tgld_pkg::*;

   localparam int TW = TICK_COUNT_WIDTH;
   localparam int CW = (TW > MS_W) ? TW : MS_W;

   logic          prev_level_ff, prev_level_in;
   logic [TW-1:0] stable_ff, stable_in;
   logic [TW-1:0] press_ff, press_in;
   logic          pressed_ff, pressed_in;
   logic          handled_ff, handled_in;
   logic          accept;
   logic          lvl;
   logic          short_press;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign accept       = req_ch.valid && push_ready;
   assign lvl          = req_ch.pin_level;

   always_comb begin
      press_in      = (press_ff == '1) ? press_ff : press_ff + 1'b1;
      stable_in     = (lvl != prev_level_ff) ? '0 :
                      ((stable_ff == '1) ? stable_ff : stable_ff + 1'b1);
      pressed_in    = pressed_ff;
      handled_in    = handled_ff;
      prev_level_in = lvl;
      short_press   = 1'b0;
      if (CW'(stable_in) > CW'(cfg.debounce_ms)) begin
         if (lvl == cfg.active_level && !pressed_ff) begin
            pressed_in = 1'b1;
            press_in   = '0;
            handled_in = 1'b0;
         end else if (lvl != cfg.active_level && pressed_ff) begin
            pressed_in = 1'b0;
            if (!handled_ff && (!cfg.gestures_enabled ||
                                CW'(press_in) < CW'(cfg.medium_ms))) begin
               short_press = 1'b1;
            end
            handled_in = 1'b0;
         end
      end
      // long hold marks the press handled here so the next release sees it
      push_data.hold_start = cfg.gestures_enabled && pressed_in && !handled_in &&
                             (CW'(press_in) >= CW'(cfg.long_ms));
      if (push_data.hold_start) begin
         handled_in = 1'b1;
      end
      push_data.short_press = short_press;
      push_data.pressed     = pressed_in;
      push_data.in_window   = (CW'(press_in) >= CW'(cfg.medium_ms)) &&
                              (CW'(press_in) < CW'(cfg.long_ms));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= ~ACTIVE_RST;
         stable_ff     <= '0;
         press_ff      <= '0;
         pressed_ff    <= 1'b0;
         handled_ff    <= 1'b0;
      end else if (accept) begin
         prev_level_ff <= prev_level_in;
         stable_ff     <= stable_in;
         press_ff      <= press_in;
         pressed_ff    <= pressed_in;
         handled_ff    <= handled_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/tgld_queue.sv -----
// tgld_queue: short fifo of classified ticks between front and back
// depends on: tgld_pkg
`default_nettype none

module tgld_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire tgld_pkg::tgld_event_type push_data,
   output logic                          pop_valid,
   input  wire logic                     pop_ready,
   output tgld_pkg::tgld_event_type      pop_data
);
   import tgld_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   tgld_event_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != NW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/tgld_back.sv -----
// tgld_back: led state, brightness ramp with square root start, result register
// depends on: tgld_pkg, tgld_if
`default_nettype none

module tgld_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tgld_pkg::tgld_cfg_type   cfg,
   input  wire logic                     pop_valid,
   output logic                          pop_ready,
   input  wire tgld_pkg::tgld_event_type pop_data,
   tgld_rsp_if.source                    rsp_ch
);
   import tgld_pkg::*;

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_ROOT  = 3'b010,
      ST_APPLY = 3'b100
   } tgld_state_type;

   tgld_state_type state_ff, state_in;

   logic               ramping_ff, ramping_in;
   logic               rising_ff, rising_in;
   logic [LEVEL_W-1:0] pos_ff, pos_in;
   logic [7:0]         rticks_ff, rticks_in;
   logic               was_ff, was_in;
   logic               led_ff, led_in;
   logic [LEVEL_W-1:0] bright_ff, bright_in;
   logic [LEVEL_W-1:0] duty_ff, duty_in;
   logic               save;
   logic               need_root;

   logic [LEVEL_W-1:0]   root_ff;
   logic [2:0]           bit_ff;
   logic [2*LEVEL_W-1:0] root_n_ff;
   logic [LEVEL_W-1:0]   root_try;
   logic [2*LEVEL_W-1:0] root_sq;
   logic [2*LEVEL_W-1:0] gamma_sum;

   logic rsp_valid_ff;
   logic out_free;
   logic commit;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // one tick of the led step; in the downward start case pos comes from root_ff
   always_comb begin
      ramping_in = ramping_ff;
      rising_in  = rising_ff;
      pos_in     = pos_ff;
      rticks_in  = (rticks_ff == 8'hFF) ? rticks_ff : rticks_ff + 1'b1;
      led_in     = led_ff;
      bright_in  = bright_ff;
      duty_in    = duty_ff;
      save       = 1'b0;
      need_root  = 1'b0;
      gamma_sum  = '0;
      if (cfg.gestures_enabled) begin
         if (pop_data.hold_start && !ramping_ff) begin
            if (!led_ff || bright_ff == '0) begin
               rising_in = 1'b1;
               pos_in    = '0;
               led_in    = 1'b1;
            end else begin
               rising_in = 1'b0;
               pos_in    = root_ff;
               need_root = 1'b1;
            end
            ramping_in = 1'b1;
            rticks_in  = '0;
         end
         if (ramping_in && pop_data.pressed) begin
            if (rticks_in >= cfg.ramp_interval_ms) begin
               rticks_in = '0;
               if (rising_in) begin
                  if (pos_in != LEVEL_MAX) pos_in = pos_in + 1'b1;
               end else begin
                  if (pos_in != '0) pos_in = pos_in - 1'b1;
               end
               // quadratic gamma
               gamma_sum = {{LEVEL_W{1'b0}}, pos_in} * {{LEVEL_W{1'b0}}, pos_in}
                           + {{LEVEL_W{1'b0}}, pos_in};
               bright_in = gamma_sum[2*LEVEL_W-1:LEVEL_W];
               if (bright_in == '0 && !rising_in) begin
                  led_in  = 1'b0;
                  duty_in = '0;
               end else begin
                  duty_in = bright_in;
               end
            end
         end else if (was_ff && !pop_data.pressed) begin
            if (ramping_in) begin
               ramping_in = 1'b0;
               save       = 1'b1;
            end else if (pop_data.in_window) begin
               led_in = !led_ff;
               if (led_in) begin
                  if (bright_ff == '0) bright_in = LEVEL_RST;
                  duty_in = bright_in;
               end else begin
                  duty_in = '0;
               end
               save = 1'b1;
            end
         end
      end
      was_in = pop_data.pressed;
   end

   // one restoring square root bit per cycle
   assign root_try = root_ff | (LEVEL_W'(1) << bit_ff);
   assign root_sq  = {{LEVEL_W{1'b0}}, root_try} * {{LEVEL_W{1'b0}}, root_try};

   always_comb begin
      state_in = state_ff;
      commit   = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (pop_valid && out_free) begin
               if (need_root) begin
                  state_in = ST_ROOT;
               end else begin
                  commit = 1'b1;
               end
            end
         end
         ST_ROOT: begin
            if (bit_ff == '0) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   assign pop_ready = commit;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN) begin
         root_ff   <= '0;
         bit_ff    <= 3'd7;
         // brightness times 255
         root_n_ff <= {bright_ff, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, bright_ff};
      end else if (state_ff == ST_ROOT) begin
         if (root_sq <= root_n_ff) root_ff <= root_try;
         bit_ff <= bit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         ramping_ff   <= 1'b0;
         rising_ff    <= 1'b1;
         pos_ff       <= '0;
         rticks_ff    <= '0;
         was_ff       <= 1'b0;
         led_ff       <= 1'b0;
         bright_ff    <= LEVEL_RST;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            ramping_ff   <= ramping_in;
            rising_ff    <= rising_in;
            pos_ff       <= pos_in;
            rticks_ff    <= rticks_in;
            was_ff       <= was_in;
            led_ff       <= led_in;
            bright_ff    <= bright_in;
            duty_ff      <= duty_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ch.short_press   <= pop_data.short_press;
         rsp_ch.pwm_duty      <= duty_in;
         rsp_ch.led_on        <= led_in;
         rsp_ch.level_setting <= bright_in;
         rsp_ch.save_request  <= save;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- dv/tgld_tb_pkg.sv -----
`timescale 1ns / 100ps
// tgld_tb_pkg: tick predictor and result scoreboard for the touch gesture led dimmer
// depends on: tgld_pkg

package tgld_tb_pkg;

   import tgld_pkg::*;

   localparam int TB_TICK_W = TICK_COUNT_WIDTH_DEF;
   localparam logic [TB_TICK_W-1:0] TICK_SAT = '1;

   typedef struct packed {
      logic               short_press;
      logic [LEVEL_W-1:0] pwm_duty;
      logic               led_on;
      logic [LEVEL_W-1:0] level_setting;
      logic               save_request;
   } tick_result_type;

   class dimmer_predictor;
      tgld_cfg_type          cfg;
      logic                  prev_level;
      logic [TB_TICK_W-1:0]  stable_ticks;
      logic [TB_TICK_W-1:0]  press_ticks;
      bit                    is_pressed, is_handled, ramping, ramp_rising;
      bit                    was_pressed, led_enabled;
      logic [LEVEL_W-1:0]    ramp_pos, ramp_ticks, brightness, duty_now;
      tick_result_type       expected_ticks[$];
      int unsigned           failures;

      function new();
         cfg.debounce_ms      = DEBOUNCE_RST;
         cfg.active_level     = ACTIVE_RST;
         cfg.medium_ms        = MEDIUM_RST;
         cfg.long_ms          = LONG_RST;
         cfg.ramp_interval_ms = INTERVAL_RST;
         cfg.gestures_enabled = GESTURE_RST;
         prev_level   = ~ACTIVE_RST;
         stable_ticks = '0;
         press_ticks  = '0;
         is_pressed   = 0;
         is_handled   = 0;
         ramping      = 0;
         ramp_rising  = 1;
         ramp_pos     = '0;
         ramp_ticks   = '0;
         was_pressed  = 0;
         led_enabled  = 0;
         brightness   = LEVEL_RST;
         duty_now     = '0;
         failures     = 0;
      endfunction

      // register write, masked to the field width; spare indexes do nothing
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_DEBOUNCE: cfg.debounce_ms      = data[DEBOUNCE_W-1:0];
            REG_ACTIVE:   cfg.active_level     = data[0];
            REG_MEDIUM:   cfg.medium_ms        = data[MS_W-1:0];
            REG_LONG:     cfg.long_ms          = data[MS_W-1:0];
            REG_INTERVAL: cfg.ramp_interval_ms = data[INTERVAL_W-1:0];
            REG_GESTURE:  cfg.gestures_enabled = data[0];
            default: ;
         endcase
      endfunction

      function logic [LEVEL_W-1:0] floor_root(logic [15:0] n);
         logic [LEVEL_W-1:0] root, trial;
         logic [15:0]        wide;
         root = '0;
         for (int b = LEVEL_W - 1; b >= 0; b--) begin
            trial = root | (8'd1 << b);
            wide  = trial;
            if (wide * wide <= n) root = trial;
         end
         return root;
      endfunction

      // quadratic gamma: (p*p + p) >> 8
      function logic [LEVEL_W-1:0] gamma_of(logic [LEVEL_W-1:0] p);
         logic [15:0] wide;
         wide = p;
         wide = wide * wide + wide;
         return wide[15:8];
      endfunction

      function void note_tick(logic pin);
         tick_result_type      r;
         logic [TB_TICK_W-1:0] dur;
         logic [15:0]          scaled;
         bit                   done;
         r = '0;
         done = 0;
         if (press_ticks != TICK_SAT) press_ticks++;
         if (ramp_ticks != LEVEL_MAX) ramp_ticks++;

         // debounce
         if (pin != prev_level) stable_ticks = '0;
         else if (stable_ticks != TICK_SAT) stable_ticks++;
         if (stable_ticks > cfg.debounce_ms) begin
            if (pin == cfg.active_level && !is_pressed) begin
               is_pressed  = 1;
               press_ticks = '0;
               is_handled  = 0;
            end else if (pin != cfg.active_level && is_pressed) begin
               is_pressed = 0;
               if (!is_handled && (!cfg.gestures_enabled || press_ticks < cfg.medium_ms))
                  r.short_press = 1'b1;
               is_handled = 0;
            end
         end
         prev_level = pin;

         // led gestures
         if (cfg.gestures_enabled) begin
            dur = press_ticks;
            if (is_pressed && !is_handled && dur >= cfg.long_ms) begin
               is_handled = 1;
               if (!ramping) begin
                  if (!led_enabled || brightness == '0) begin
                     ramp_rising = 1;
                     ramp_pos    = '0;
                     led_enabled = 1;
                  end else begin
                     ramp_rising = 0;
                     scaled      = brightness * 16'd255;
                     ramp_pos    = floor_root(scaled);
                  end
                  ramping    = 1;
                  ramp_ticks = '0;
               end
            end
            if (ramping && is_pressed) begin
               if (ramp_ticks >= cfg.ramp_interval_ms) begin
                  ramp_ticks = '0;
                  if (ramp_rising) begin
                     if (ramp_pos != LEVEL_MAX) ramp_pos++;
                  end else if (ramp_pos != '0) begin
                     ramp_pos--;
                  end
                  brightness = gamma_of(ramp_pos);
                  if (brightness == '0 && !ramp_rising) begin
                     led_enabled = 0;
                     duty_now    = '0;
                  end else begin
                     duty_now = brightness;
                  end
               end
               done = 1;
            end
            if (!done && was_pressed && !is_pressed) begin
               if (ramping) begin
                  ramping = 0;
                  r.save_request = 1'b1;
               end else if (dur >= cfg.medium_ms && dur < cfg.long_ms) begin
                  led_enabled = !led_enabled;
                  if (led_enabled) begin
                     if (brightness == '0) brightness = LEVEL_RST;
                     duty_now = brightness;
                  end else begin
                     duty_now = '0;
                  end
                  r.save_request = 1'b1;
               end
            end
         end
         was_pressed = is_pressed;

         r.pwm_duty      = duty_now;
         r.led_on        = led_enabled;
         r.level_setting = brightness;
         expected_ticks.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_tick(tick_result_type got);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = expected_ticks.pop_front();
         compare_field("short_press", want.short_press, got.short_press);
         compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
         compare_field("led_on", want.led_on, got.led_on);
         compare_field("level_setting", want.level_setting, got.level_setting);
         compare_field("save_request", want.save_request, got.save_request);
      endfunction

      function int unsigned pending();
         return expected_ticks.size();
      endfunction
   endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives pin level ticks and register writes into the dimmer, checks every result
// depends on: tgld_pkg, tgld_if, tgld_tb_pkg, touch_gesture_led_dimmer

module tb_top;

   import tgld_pkg::*;
   import tgld_tb_pkg::*;

   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 6;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 2_000_000;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tgld_req_if req_ch ();
   tgld_rsp_if rsp_ch ();

   dimmer_predictor sb = new();

   bit          req_idle_on;
   bit          rsp_idle_on;
   int unsigned hold_off_asked;
   int unsigned hold_off_served;
   int unsigned ticks_sent;
   int unsigned cycle_count;

   touch_gesture_led_dimmer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // offer one tick, return at the edge where it is taken
   task automatic send_tick(input logic pin);
      int unsigned gap;
      gap = req_idle_on ? idle_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.pin_level <= pin;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sb.note_tick(pin);
      ticks_sent++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      sb.write_reg(idx, data[CSR_DATA_W-1:0]);
   endtask

   // register writes only while idle: drained, then the back end given time to settle
   task automatic apply_config(input int unsigned deb, input int unsigned act,
                               input int unsigned med, input int unsigned lng,
                               input int unsigned itv, input int unsigned gst);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      // spare index write first, must be ignored
      csr_put($urandom_range(0, 1) ? SPARE_IDX_HI : SPARE_IDX_LO, $urandom_range(0, 16383));
      csr_put(REG_DEBOUNCE, deb);
      csr_put(REG_ACTIVE, act);
      csr_put(REG_MEDIUM, med);
      csr_put(REG_LONG, lng);
      csr_put(REG_INTERVAL, itv);
      csr_put(REG_GESTURE, gst);
      csr_wr_en <= 1'b0;
   endtask

   // one touch: optional bounce, held at the active level, then released
   task automatic press(input int unsigned held, input int unsigned released, input bit bouncy);
      logic act;
      act = sb.cfg.active_level;
      if (bouncy) begin
         repeat ($urandom_range(1, 3)) begin
            send_tick(act);
            send_tick(!act);
         end
      end
      repeat (held) send_tick(act);
      repeat (released) send_tick(!act);
   endtask

   // mostly well formed presses of every length class, plus noise and broken ones
   task automatic run_gestures(input int unsigned count);
      int unsigned start, settle, med, lng, held, rel, kind;
      start = ticks_sent;
      while (ticks_sent - start < count) begin
         settle = sb.cfg.debounce_ms + 1;
         med    = sb.cfg.medium_ms;
         lng    = sb.cfg.long_ms;
         rel    = settle + $urandom_range(0, 4);
         kind   = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: held = $urandom_range(settle, settle + med);
            3, 4: held = med + $urandom_range(0, (lng > med) ? lng - med : 1);
            5, 6: begin
               held = lng + $urandom_range(0, 60);
               if ($urandom_range(0, 7) == 0) held += $urandom_range(150, 300);
            end
            8: held = $urandom_range(1, settle);          // too short to register
            default: begin
               held = $urandom_range(settle, settle + med);
               rel  = $urandom_range(1, settle);          // release bounced back too soon
            end
         endcase
         if (kind == 7) begin
            // pure noise
            repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
         end else begin
            press((held < 1) ? 1 : held, rel, $urandom_range(0, 3) == 0);
         end
      end
   endtask

   // result side: check every taken result, stall at random or on request
   initial begin : result_sink
      int unsigned     stall_left;
      tick_result_type got;
      stall_left      = 0;
      hold_off_served = 0;
      rsp_ch.ready    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.short_press   = rsp_ch.short_press;
            got.pwm_duty      = rsp_ch.pwm_duty;
            got.led_on        = rsp_ch.led_on;
            got.level_setting = rsp_ch.level_setting;
            got.save_request  = rsp_ch.save_request;
            sb.check_tick(got);
         end
         // long hold off so the queue fills and the input stalls
         if (hold_off_served != hold_off_asked) begin
            hold_off_served = hold_off_asked;
            stall_left      = LONG_HOLD_CYCLES;
         end
         if (stall_left == 0 && rsp_idle_on) stall_left = idle_gap();
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      req_ch.valid     = 1'b0;
      req_ch.pin_level = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_DEBOUNCE;
      csr_wdata        = '0;
      req_idle_on      = 0;
      rsp_idle_on      = 0;
      hold_off_asked   = 0;
      ticks_sent       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // a few ticks at reset settings: slow debounce keeps everything idle
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);

      // directed: zero debounce, short press, toggle, long hold into a ramp
      apply_config(0, 1, 3, 6, 0, 1);
      press(2, 2, 0);
      press(4, 2, 0);
      press(9, 2, 0);

      // full ramp up, ramp down to zero which turns the led off,
      // then a toggle on with zero brightness restoring the default level
      apply_config(1, 1, 2, 4, 0, 1);
      if (!sb.led_enabled) press(300, 3, 0);
      press(300, 3, 0);
      press(3, 4, 0);

      // random presses with idling on both sides
      apply_config(2, 1, 8, 20, 3, 1);
      req_idle_on = 1;
      rsp_idle_on = 1;
      run_gestures(40);
      // receiver holds off while the sender keeps offering back to back
      req_idle_on = 0;
      hold_off_asked++;
      run_gestures(30);
      req_idle_on = 1;
      // sender pauses until everything is back
      drain();
      run_gestures(40);

      // active low pin, zero ramp interval
      apply_config(0, 0, 5, 12, 0, 1);
      run_gestures(90);

      // gestures disabled: every release is a short press, led holds
      apply_config(3, 1, 10, 30, 1, 0);
      rsp_idle_on = 0;
      run_gestures(80);
      rsp_idle_on = 1;

      // medium equal to long: empty toggle window
      apply_config(1, 1, 15, 15, 2, 1);
      req_idle_on = 0;
      run_gestures(100);
      req_idle_on = 1;

      // medium above long
      apply_config(4, 0, 40, 10, 1, 1);
      run_gestures(75);

      // smallest thresholds
      apply_config(0, 1, 1, 1, 1, 1);
      run_gestures(50);

      repeat (2) begin
         apply_config($urandom_range(0, 5), $urandom_range(0, 1), $urandom_range(1, 40),
                      $urandom_range(1, 40), $urandom_range(0, 6),
                      ($urandom_range(0, 3) != 0) ? 1 : 0);
         run_gestures(75);
      end

      // extremes: all ones into the debounce field (masked), longest long threshold,
      // slowest ramp; a touch far too short for the widest debounce
      apply_config(16383, 1, 10000, 16383, 255, 1);
      req_idle_on = 0;
      rsp_idle_on = 0;
      press(40, 30, 0);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0t: %0d results still outstanding", $time, sb.pending());
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/tgld_pkg.sv
design/tgld_if.sv
design/tgld_front.sv
design/tgld_queue.sv
design/tgld_back.sv
design/touch_gesture_led_dimmer.sv
dv/tgld_tb_pkg.sv
dv/tb_top.sv
